### design/msplit_pkg.sv
// Shared types and constants for the move segment splitter.
`default_nettype none
package msplit_pkg;

  localparam int MAX_PIECES = 64;
  localparam int FRAC_BITS  = 16;
  localparam int PIECE_W    = $clog2(MAX_PIECES);
  localparam int LEN_W      = 33;
  localparam int STEP_W     = 31;
  localparam int ACC_W      = 40;
  localparam int SQRT_STEPS = 33;
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(((2 << FRAC_BITS) + 2) / 5);

  typedef struct packed {
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] seg_start_x;
    logic signed [31:0] seg_start_y;
    logic signed [31:0] seg_start_z;
    logic signed [31:0] seg_end_x;
    logic signed [31:0] seg_end_y;
    logic signed [31:0] seg_end_z;
    logic               last_piece;
    logic               overlong;
  } out_t;

  typedef struct packed {
    logic       load_in;
    logic       mul_sq;
    logic       acc_sq;
    logic       sqrt_go;
    logic       ndiv_go;
    logic       ndiv_cap;
    logic       mul_off;
    logic       odiv_go;
    logic       odiv_cap;
    logic       seg_init;
    logic       seg_load;
    logic       fin_load;
    logic [1:0] ax;
  } cmd_t;

  typedef struct packed {
    logic               sqrt_done;
    logic               div_done;
    logic               n_zero;
    logic [PIECE_W-1:0] n;
    logic               out_free;
  } sts_t;

endpackage
`default_nettype wire

### design/msplit_sqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
`default_nettype none
module msplit_sqrt (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [2*msplit_pkg::LEN_W-1:0] rad_i,
  output logic                           done_o,
  output logic [msplit_pkg::LEN_W-1:0]   root_o
);
  import msplit_pkg::*;

  logic [2*LEN_W-1:0] rad_q;
  logic [34:0]        rem_q;
  logic [LEN_W-1:0]   root_q;
  logic [5:0]         cnt_q;
  logic               busy_q, done_q;
  logic [36:0]        rem_sh, trial;
  logic               take;

  assign rem_sh = {rem_q, rad_q[2*LEN_W-1 -: 2]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign take   = (rem_sh >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rad_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'(SQRT_STEPS);
        rad_q  <= rad_i;
        rem_q  <= '0;
        root_q <= '0;
      end else if (busy_q) begin
        rad_q  <= rad_q << 2;
        rem_q  <= take ? 35'(rem_sh - trial) : rem_sh[34:0];
        root_q <= {root_q[LEN_W-2:0], take};
        cnt_q  <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule
`default_nettype wire

### design/msplit_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module msplit_div (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic [msplit_pkg::LEN_W-1:0] rem0_i,
  input  wire logic [63:0]             num_i,
  input  wire logic [6:0]              steps_i,
  input  wire logic [msplit_pkg::LEN_W-1:0] dvs_i,
  output logic                         done_o,
  output logic [msplit_pkg::LEN_W-1:0] quo_o
);
  import msplit_pkg::*;

  logic [LEN_W-1:0] rem_q, dvs_q, quo_q;
  logic [63:0]      num_q;
  logic [6:0]       cnt_q;
  logic             busy_q, done_q;
  logic [LEN_W:0]   rsh;
  logic             take;

  assign rsh  = {rem_q, num_q[63]};
  assign take = (rsh >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      quo_q  <= '0;
      num_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        rem_q  <= rem0_i;
        num_q  <= num_i;
        cnt_q  <= steps_i;
        dvs_q  <= dvs_i;
        quo_q  <= '0;
      end else if (busy_q) begin
        rem_q <= take ? LEN_W'(rsh - {1'b0, dvs_q}) : rsh[LEN_W-1:0];
        num_q <= num_q << 1;
        quo_q <= {quo_q[LEN_W-2:0], take};
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule
`default_nettype wire

### design/msplit_dp.sv
// Datapath: deltas, shared multiplier, root and divider units, point walk, output register.
`default_nettype none
module msplit_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire msplit_pkg::in_t             in_data_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [msplit_pkg::STEP_W-1:0] cfg_data_i,
  input  wire msplit_pkg::cmd_t            cmd_i,
  output msplit_pkg::sts_t                 sts_o,
  input  wire logic                        out_stall_i,
  output logic                             out_valid_o,
  output msplit_pkg::out_t                 out_data_o
);
  import msplit_pkg::*;

  logic [STEP_W-1:0]       step_q;
  logic signed [31:0]      last_q [3];
  logic signed [31:0]      tgt_q  [3];
  logic signed [LEN_W-1:0] d_q    [3];
  logic signed [33:0]      off_q  [3];
  logic signed [ACC_W-1:0] acc_q  [3];
  logic signed [31:0]      p0_q   [3];
  logic signed [31:0]      tin    [3];
  logic signed [ACC_W-1:0] acc_n  [3];
  logic signed [31:0]      p1     [3];
  logic [2*LEN_W-1:0]      prod_q, sumsq_q;
  logic [LEN_W-1:0]        len_q, mag_sel, opb, s_eff, len_m1, quo, root;
  logic [PIECE_W-1:0]      n_q;
  logic                    ovl_q, sqrt_done, div_done;
  logic                    out_valid_q, out_free;
  out_t                    out_q;
  logic [63:0]             nsum, div_num;
  logic [LEN_W-1:0]        div_rem0, div_dvs;
  logic [6:0]              div_steps;
  logic signed [33:0]      qext;

  assign tin[0] = in_data_i.target_x;
  assign tin[1] = in_data_i.target_y;
  assign tin[2] = in_data_i.target_z;

  assign s_eff   = (step_q == '0) ? LEN_W'(1) : {2'b00, step_q};
  assign mag_sel = d_q[cmd_i.ax][LEN_W-1] ? LEN_W'(-d_q[cmd_i.ax]) : d_q[cmd_i.ax];
  assign opb     = cmd_i.mul_sq ? mag_sel : s_eff;
  assign len_m1  = len_q - LEN_W'(1);
  assign nsum    = prod_q[63:0] + {32'b0, len_q[LEN_W-1:1]};

  // n = (len - 1) / s uses the top of the numerator; offsets start with the
  // high half already in the remainder since the quotient fits 32 bits
  assign div_rem0  = cmd_i.ndiv_go ? '0 : {1'b0, nsum[63:32]};
  assign div_num   = cmd_i.ndiv_go ? {len_m1, 31'b0} : {nsum[31:0], 32'b0};
  assign div_steps = cmd_i.ndiv_go ? 7'd33 : 7'd32;
  assign div_dvs   = cmd_i.ndiv_go ? s_eff : len_q;
  assign qext      = {2'b00, quo[31:0]};

  msplit_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_go),
    .rad_i   (sumsq_q),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  msplit_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.ndiv_go | cmd_i.odiv_go),
    .rem0_i  (div_rem0),
    .num_i   (div_num),
    .steps_i (div_steps),
    .dvs_i   (div_dvs),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc_n[i] = acc_q[i] + ACC_W'(off_q[i]);
      if (acc_n[i] > ACC_W'(32'sh7fffffff)) begin
        p1[i] = 32'sh7fffffff;
      end else if (acc_n[i] < -ACC_W'(64'sh80000000)) begin
        p1[i] = 32'sh80000000;
      end else begin
        p1[i] = acc_n[i][31:0];
      end
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_RESET;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        last_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        step_q <= cfg_data_i;
      end
      if (cmd_i.seg_load || cmd_i.fin_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.fin_load) begin
        for (int i = 0; i < 3; i++) begin
          last_q[i] <= tgt_q[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      sumsq_q <= '0;
      for (int i = 0; i < 3; i++) begin
        tgt_q[i] <= tin[i];
        d_q[i]   <= LEN_W'(tin[i]) - LEN_W'(last_q[i]);
      end
    end
    if (cmd_i.mul_sq || cmd_i.mul_off) begin
      prod_q <= mag_sel * opb;
    end
    if (cmd_i.acc_sq) begin
      sumsq_q <= sumsq_q + prod_q;
    end
    if (sqrt_done) begin
      len_q <= root;
    end
    if (div_done && cmd_i.ndiv_cap) begin
      if (len_q == '0) begin
        n_q   <= '0;
        ovl_q <= 1'b0;
      end else if (quo > LEN_W'(MAX_PIECES - 1)) begin
        n_q   <= PIECE_W'(MAX_PIECES - 1);
        ovl_q <= 1'b1;
      end else begin
        n_q   <= quo[PIECE_W-1:0];
        ovl_q <= 1'b0;
      end
    end
    if (div_done && cmd_i.odiv_cap) begin
      off_q[cmd_i.ax] <= d_q[cmd_i.ax][LEN_W-1] ? -qext : qext;
    end
    if (cmd_i.seg_init) begin
      for (int i = 0; i < 3; i++) begin
        acc_q[i] <= ACC_W'(last_q[i]);
        p0_q[i]  <= last_q[i];
      end
    end
    if (cmd_i.seg_load) begin
      out_q.seg_start_x <= p0_q[0];
      out_q.seg_start_y <= p0_q[1];
      out_q.seg_start_z <= p0_q[2];
      out_q.seg_end_x   <= p1[0];
      out_q.seg_end_y   <= p1[1];
      out_q.seg_end_z   <= p1[2];
      out_q.last_piece  <= 1'b0;
      out_q.overlong    <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        acc_q[i] <= acc_n[i];
        p0_q[i]  <= p1[i];
      end
    end
    if (cmd_i.fin_load) begin
      out_q.seg_start_x <= p0_q[0];
      out_q.seg_start_y <= p0_q[1];
      out_q.seg_start_z <= p0_q[2];
      out_q.seg_end_x   <= tgt_q[0];
      out_q.seg_end_y   <= tgt_q[1];
      out_q.seg_end_z   <= tgt_q[2];
      out_q.last_piece  <= 1'b1;
      out_q.overlong    <= ovl_q;
    end
  end

  assign sts_o.sqrt_done = sqrt_done;
  assign sts_o.div_done  = div_done;
  assign sts_o.n_zero    = (n_q == '0);
  assign sts_o.n         = n_q;
  assign sts_o.out_free  = out_free;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;
endmodule
`default_nettype wire

### design/msplit_ctrl.sv
// Controller: sequences the datapath through one move.
`default_nettype none
module msplit_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire msplit_pkg::sts_t sts_i,
  output msplit_pkg::cmd_t      cmd_o
);
  import msplit_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ, ST_ACC, ST_SQRT_GO, ST_SQRT_WT, ST_NDIV_GO, ST_NDIV_WT,
    ST_MUL, ST_ODIV_GO, ST_ODIV_WT, ST_INIT, ST_SEG, ST_FIN
  } state_e;

  state_e             state_q;
  logic [1:0]         ax_q;
  logic [PIECE_W-1:0] k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ax_q    <= '0;
      k_q     <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_SQ;
            ax_q    <= '0;
          end
        end
        ST_SQ: state_q <= ST_ACC;
        ST_ACC: begin
          if (ax_q == 2'd2) begin
            state_q <= ST_SQRT_GO;
          end else begin
            ax_q    <= ax_q + 2'd1;
            state_q <= ST_SQ;
          end
        end
        ST_SQRT_GO: state_q <= ST_SQRT_WT;
        ST_SQRT_WT: if (sts_i.sqrt_done) state_q <= ST_NDIV_GO;
        ST_NDIV_GO: state_q <= ST_NDIV_WT;
        ST_NDIV_WT: begin
          if (sts_i.div_done) begin
            state_q <= ST_MUL;
            ax_q    <= '0;
          end
        end
        ST_MUL: begin
          // skip the step vector when no full step fits
          state_q <= sts_i.n_zero ? ST_INIT : ST_ODIV_GO;
        end
        ST_ODIV_GO: state_q <= ST_ODIV_WT;
        ST_ODIV_WT: begin
          if (sts_i.div_done) begin
            if (ax_q == 2'd2) begin
              state_q <= ST_INIT;
            end else begin
              ax_q    <= ax_q + 2'd1;
              state_q <= ST_MUL;
            end
          end
        end
        ST_INIT: begin
          k_q     <= '0;
          state_q <= sts_i.n_zero ? ST_FIN : ST_SEG;
        end
        ST_SEG: begin
          if (sts_i.out_free) begin
            k_q <= k_q + PIECE_W'(1);
            if (k_q == sts_i.n - PIECE_W'(1)) begin
              state_q <= ST_FIN;
            end
          end
        end
        ST_FIN: if (sts_i.out_free) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.ax       = ax_q;
    cmd_o.load_in  = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.mul_sq   = (state_q == ST_SQ);
    cmd_o.acc_sq   = (state_q == ST_ACC);
    cmd_o.sqrt_go  = (state_q == ST_SQRT_GO);
    cmd_o.ndiv_go  = (state_q == ST_NDIV_GO);
    cmd_o.ndiv_cap = (state_q == ST_NDIV_WT);
    cmd_o.mul_off  = (state_q == ST_MUL);
    cmd_o.odiv_go  = (state_q == ST_ODIV_GO);
    cmd_o.odiv_cap = (state_q == ST_ODIV_WT);
    cmd_o.seg_init = (state_q == ST_INIT);
    cmd_o.seg_load = (state_q == ST_SEG) && sts_i.out_free;
    cmd_o.fin_load = (state_q == ST_FIN) && sts_i.out_free;
  end

  assign in_stall_o = (state_q != ST_IDLE);
endmodule
`default_nettype wire

### design/move_segment_splitter.sv
// Top level of the move segment splitter.
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one target point
//   per request, signed Q16.16. Output channel (out_valid_o / out_stall_i /
//   out_data_o) gives the segments from the previous point to the target: full
//   steps of step_length first, then the final piece marked last_piece, with
//   overlong set when the piece limit of 64 cut the split short.
//   cfg_we_i / cfg_data_i write step_length; write only while idle.
// Timing:
//   One request is worked at a time. Sum of squares comes first, then the
//   square root (one bit per cycle), the piece count division, and when
//   at least one full step fits, three offset divisions, each with a
//   multiply before it. Then one segment per cycle leaves the output
//   register while the receiver does not stall it. The next request is taken
//   as soon as the final piece sits in the output register, even if the
//   receiver still stalls it.
// Reset: previous point returns to the origin, step_length to 0.4 mm, and
//   the output register empties. A stalled output holds its request.
`default_nettype none
module move_segment_splitter (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire msplit_pkg::in_t                 in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output msplit_pkg::out_t                     out_data_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [msplit_pkg::STEP_W-1:0]   cfg_data_i
);
  import msplit_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // controller: walks one request through root, divisions and emission
  msplit_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: arithmetic units, point state and output register
  msplit_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );
endmodule
`default_nettype wire

### design/msplit_chk.sv
// Port-level checker for the move segment splitter, with its bind.
`default_nettype none
module msplit_chk (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_stall_o,
  input wire logic             out_valid_o,
  input wire logic             out_stall_i,
  input wire msplit_pkg::out_t out_data_o
);
  import msplit_pkg::*;

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("output request dropped");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o)) else $error("stalled output changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o) else $error("second request taken at once");

  a_overlong_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.overlong |-> out_data_o.last_piece)
    else $error("overlong flag on a full step");
endmodule

bind move_segment_splitter msplit_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire
